// ===== src/adtg_pkg.sv =====
// Shared types and constants of the audio DMA tick generator.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package adtg_pkg;

  localparam int unsigned CyclesW        = 10;
  localparam int unsigned AddrW          = 20;
  localparam int unsigned SlotW          = 10;
  localparam int unsigned QuotW          = 17;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 32;
  localparam int unsigned PeriphRamWords = 1048576;
  localparam int unsigned TickRate       = 48000;
  localparam int unsigned MaxTicks       = 64;
  localparam int unsigned QueueDepth     = 4;
  localparam logic [31:0] ClockMinHz     = 32'd1000000;
  localparam logic [31:0] ClockResetHz   = 32'd12500000;
  localparam logic [QuotW-1:0] ResetQuot = QuotW'(ClockResetHz / TickRate);
  localparam logic [15:0] ResetRem       = 16'(ClockResetHz % TickRate);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LEFT_OFFSET  = 3'd0,
    CFG_RIGHT_OFFSET = 3'd1,
    CFG_SIZE_MASK    = 3'd2,
    CFG_RATE_DIVIDER = 3'd3,
    CFG_MAIN_CLOCK   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             busy;
    logic [QuotW-1:0] quot;
    logic [15:0]      rem;
  } clk_div_t;

  typedef struct packed {
    logic               valid;
    logic [CyclesW-1:0] cycles;
  } queue_word_t;

  typedef struct packed {
    logic [AddrW-1:0] left_address;
    logic [AddrW-1:0] right_address;
    logic             take_high_half;
    logic [SlotW-1:0] buffer_slot;
    logic [15:0]      clock_187;
    logic             half_buffer_event;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

// ===== src/adtg_in_if.sv =====
// Input channel of the tick generator: one word of elapsed cycles.
// Depends on adtg_pkg.
`default_nettype none

interface adtg_in_if;
  logic                        valid;
  logic                        ready;
  logic [adtg_pkg::CyclesW-1:0] cycles;

  modport source (output valid, output cycles, input ready);
  modport sink   (input valid, input cycles, output ready);
endinterface

`default_nettype wire

// ===== src/adtg_out_if.sv =====
// Result channel of the tick generator: one word per audio tick.
// Depends on adtg_pkg.
`default_nettype none

interface adtg_out_if;
  logic                       valid;
  logic                       ready;
  logic [adtg_pkg::AddrW-1:0] left_address;
  logic [adtg_pkg::AddrW-1:0] right_address;
  logic                       take_high_half;
  logic [adtg_pkg::SlotW-1:0] buffer_slot;
  logic [15:0]                clock_187;
  logic                       half_buffer_event;
  logic                       last;

  modport source (output valid, output left_address, output right_address,
                  output take_high_half, output buffer_slot, output clock_187,
                  output half_buffer_event, output last, input ready);
  modport sink   (input valid, input left_address, input right_address,
                  input take_high_half, input buffer_slot, input clock_187,
                  input half_buffer_event, input last, output ready);
endinterface

`default_nettype wire

// ===== src/adtg_div.sv =====
// Main clock register and its split into cycles per tick and remainder.
// Depends on adtg_pkg.
`default_nettype none

module adtg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [adtg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [adtg_pkg::CfgDataW-1:0] cfg_data_i,
  output adtg_pkg::clk_div_t                 div_o
);

  localparam logic [25:0] Recip375 = 26'd45812985;
  localparam logic [24:0] Div375   = 25'd375;

  logic                       busy_q, busy_d;
  logic                       phase_q, phase_d;
  logic [31:0]                dvd_q, dvd_d;
  logic [adtg_pkg::QuotW-1:0] quot_q, quot_d;
  logic [15:0]                rem_q, rem_d;
  logic [50:0]                prod;
  logic [24:0]                part;
  logic                       start;

  assign start = cfg_we_i &&
                 (adtg_pkg::cfg_idx_e'(cfg_idx_i) == adtg_pkg::CFG_MAIN_CLOCK);
  // hz / 48000 = (hz >> 7) / 375; the scaled reciprocal is exact for 25-bit operands
  assign prod  = 51'(dvd_q[31:7]) * 51'(Recip375);
  assign part  = dvd_q[31:7] - 25'(quot_q) * Div375;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    dvd_d   = dvd_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    if (start) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      dvd_d   = (cfg_data_i < adtg_pkg::ClockMinHz) ? adtg_pkg::ClockMinHz : cfg_data_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        phase_d = 1'b1;
        quot_d  = prod[34 +: adtg_pkg::QuotW];
      end else begin
        busy_d  = 1'b0;
        phase_d = 1'b0;
        rem_d   = {part[8:0], dvd_q[6:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      quot_q  <= adtg_pkg::ResetQuot;
      rem_q   <= adtg_pkg::ResetRem;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      quot_q  <= quot_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
  end

  assign div_o.busy = busy_q;
  assign div_o.quot = quot_q;
  assign div_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== src/adtg_front.sv =====
// Front end: takes cycle words and holds them in a short queue for the tick engine.
// Depends on adtg_pkg and adtg_in_if.
`default_nettype none

module adtg_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            div_busy_i,
  adtg_in_if.sink              in_i,
  input  wire logic            pop_i,
  output adtg_pkg::queue_word_t q_o
);

  localparam int unsigned Depth = adtg_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [adtg_pkg::CyclesW-1:0] mem_q [Depth];
  logic [PtrW-1:0]              wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]              cnt_q;
  logic                         full, push, pop;

  assign full     = (cnt_q == CntW'(Depth));
  assign in_i.ready = !full && !div_busy_i;
  assign push     = in_i.valid && in_i.ready;
  assign pop      = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.cycles;
    end
  end

  assign q_o.valid  = (cnt_q != '0);
  assign q_o.cycles = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== src/adtg_back.sv =====
// Tick engine: drains the cycle counter one tick per cycle into the result register, while the result channel accepts.
// Depends on adtg_pkg; holds the offset, mask and rate divider registers.
`default_nettype none

module adtg_back #(
  parameter int unsigned PeriphRamWords = adtg_pkg::PeriphRamWords
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [adtg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [adtg_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire adtg_pkg::clk_div_t            div_i,
  input  wire adtg_pkg::queue_word_t         q_i,
  output logic                               pop_o,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output adtg_pkg::res_t                     out_o
);

  localparam int unsigned AddrW   = adtg_pkg::AddrW;
  localparam int unsigned NW      = $clog2(adtg_pkg::MaxTicks);
  localparam logic [31:0] RamMask = 32'(PeriphRamWords - 1);
  localparam logic [16:0] Rate17  = 17'(adtg_pkg::TickRate);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TICK = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [15:0]       left_q, right_q, size_q, rdiv_q;
  logic [31:0]       rem_q, rem_d, rem_next;
  logic [15:0]       frac_q, frac_d;
  logic [9:0]        bptr_q, bptr_d;
  logic [15:0]       sc_q, sc_d, dc_q, dc_d, t48_q, t48_d, c187_q, c187_d;
  logic [NW-1:0]     n_q, n_d;
  logic              oval_q, oval_d;
  adtg_pkg::res_t    out_q, out_d;

  logic              cond, emit_ok, tick, carry, more;
  logic [16:0]       frac_sum;
  logic [15:0]       dc_inc, t48_inc;
  logic [AddrW-1:0]  ram_m, msk, imsk, s_idx;

  assign ram_m = RamMask[AddrW-1:0];
  assign msk   = {size_q, 4'b0} & ram_m;
  assign imsk  = msk ^ ram_m;
  assign s_idx = AddrW'(sc_q[15:1]);

  assign cond     = rem_q[31] || (rem_q == '0);
  assign emit_ok  = !oval_q || out_ready_i;
  assign tick     = (state_q == ST_TICK) && cond && emit_ok;
  assign frac_sum = {1'b0, frac_q} + {1'b0, div_i.rem};
  assign carry    = (frac_sum >= Rate17);
  assign rem_next = rem_q + 32'(div_i.quot) + 32'(carry);
  assign more     = (rem_next[31] || (rem_next == '0)) &&
                    (n_q != NW'(adtg_pkg::MaxTicks - 1));
  assign dc_inc   = dc_q + 16'd1;
  assign t48_inc  = t48_q + 16'd1;
  assign pop_o    = (state_q == ST_IDLE) && q_i.valid;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    frac_d  = frac_q;
    bptr_d  = bptr_q;
    sc_d    = sc_q;
    dc_d    = dc_q;
    t48_d   = t48_q;
    c187_d  = c187_q;
    n_d     = n_q;
    oval_d  = oval_q && !out_ready_i;
    out_d   = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_i.valid) begin
          rem_d   = rem_q - 32'(q_i.cycles);
          n_d     = '0;
          state_d = ST_TICK;
        end
      end
      ST_TICK: begin
        if (!cond) begin
          state_d = ST_IDLE;
        end else if (tick) begin
          rem_d  = rem_next;
          frac_d = carry ? 16'(frac_sum - Rate17) : frac_sum[15:0];
          bptr_d = bptr_q + 10'd1;
          t48_d  = t48_inc;
          if (dc_inc == rdiv_q) begin
            dc_d = '0;
            sc_d = sc_q + 16'd1;
          end else begin
            dc_d = dc_inc;
          end
          if (t48_inc[7:0] == 8'd0) begin
            c187_d = ((c187_q + 16'd1) & 16'hFF00) + {8'd0, t48_inc[15:8]};
          end
          n_d                     = n_q + 1'b1;
          oval_d                  = 1'b1;
          out_d.left_address      = ({left_q, 4'b0} & msk) | (s_idx & imsk);
          out_d.right_address     = ({right_q, 4'b0} & msk) | (s_idx & imsk);
          out_d.take_high_half    = !sc_q[0];
          out_d.buffer_slot       = bptr_q;
          out_d.clock_187         = c187_d;
          out_d.half_buffer_event = (bptr_q[8:0] == 9'h1FF);
          out_d.last              = !more;
          if (!more) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      frac_q  <= '0;
      bptr_q  <= '0;
      sc_q    <= '0;
      dc_q    <= '0;
      t48_q   <= '0;
      c187_q  <= '0;
      n_q     <= '0;
      oval_q  <= 1'b0;
      left_q  <= '0;
      right_q <= '0;
      size_q  <= '0;
      rdiv_q  <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      frac_q  <= frac_d;
      bptr_q  <= bptr_d;
      sc_q    <= sc_d;
      dc_q    <= dc_d;
      t48_q   <= t48_d;
      c187_q  <= c187_d;
      n_q     <= n_d;
      oval_q  <= oval_d;
      if (cfg_we_i) begin
        unique case (adtg_pkg::cfg_idx_e'(cfg_idx_i))
          adtg_pkg::CFG_LEFT_OFFSET:  left_q  <= cfg_data_i[15:0];
          adtg_pkg::CFG_RIGHT_OFFSET: right_q <= cfg_data_i[15:0];
          adtg_pkg::CFG_SIZE_MASK:    size_q  <= cfg_data_i[15:0];
          adtg_pkg::CFG_RATE_DIVIDER: rdiv_q  <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = oval_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== src/audio_dma_tick_generator.sv =====
// Top level of the audio DMA tick generator.
// Depends on adtg_pkg, adtg_in_if, adtg_out_if, adtg_div, adtg_front and adtg_back.
//
// Each input word gives the main-clock cycles elapsed; the block answers with
// zero or more 48 kHz tick words, the final one of an item marked by last.
// Input words enter a four-word queue, one per cycle while the queue has room and
// no division runs. The tick engine takes a word from the queue, then spends one
// cycle per tick it emits (up to 52, never more than 64); a stalled result channel
// stalls the engine. Writing main_clock_hz starts a division of the clock by
// 48000 (a reciprocal multiply, then the remainder), and the input is held off
// until it finishes.
`default_nettype none

module audio_dma_tick_generator #(
  parameter int unsigned PeriphRamWords = adtg_pkg::PeriphRamWords
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [adtg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [adtg_pkg::CfgDataW-1:0] cfg_data_i,
  adtg_in_if.sink                            in_i,
  adtg_out_if.source                         out_o
);

  adtg_pkg::clk_div_t    div;
  adtg_pkg::queue_word_t q_word;
  adtg_pkg::res_t        res;
  logic                  pop;

  adtg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .div_o      (div)
  );

  adtg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .div_busy_i (div.busy),
    .in_i       (in_i),
    .pop_i      (pop),
    .q_o        (q_word)
  );

  adtg_back #(
    .PeriphRamWords (PeriphRamWords)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .div_i       (div),
    .q_i         (q_word),
    .pop_o       (pop),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_o       (res)
  );

  assign out_o.left_address      = res.left_address;
  assign out_o.right_address     = res.right_address;
  assign out_o.take_high_half    = res.take_high_half;
  assign out_o.buffer_slot       = res.buffer_slot;
  assign out_o.clock_187         = res.clock_187;
  assign out_o.half_buffer_event = res.half_buffer_event;
  assign out_o.last              = res.last;

endmodule

`default_nettype wire

// ===== src/adtg_checker.sv =====
// Port-level assertions for the tick generator, bound to the top level.
// Depends on adtg_pkg and audio_dma_tick_generator.
`default_nettype none

module adtg_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_we_i,
  input wire logic [adtg_pkg::CfgIdxW-1:0] cfg_idx_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [adtg_pkg::SlotW-1:0]   out_slot_i,
  input wire logic                         out_half_i
);

  logic                       fire;
  logic                       have_q;
  logic [adtg_pkg::SlotW-1:0] prev_q;

  assign fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      prev_q <= '0;
    end else if (fire) begin
      have_q <= 1'b1;
      prev_q <= out_slot_i;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i))
    else $error("result word dropped or changed under stall");

  a_half_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_half_i == (out_slot_i[8:0] == 9'h1FF)))
    else $error("half buffer flag disagrees with slot");

  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && have_q |-> (out_slot_i == adtg_pkg::SlotW'(prev_q + 1'b1)))
    else $error("buffer slot skipped or repeated");

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == adtg_pkg::CFG_MAIN_CLOCK) |=> !in_ready_i)
    else $error("input taken while clock division runs");

endmodule

bind audio_dma_tick_generator adtg_checker u_adtg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_slot_i  (out_o.buffer_slot),
  .out_half_i  (out_o.half_buffer_event)
);

`default_nettype wire
